// ----- rtl/kmsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsd_pkg
// Shared widths, reset values and the result record of the keypad scanner.
// ----------------------------------------------------------------------------
package kmsd_pkg;

    localparam int COUNT_W     = 3;
    localparam int LEVELS_W    = 4;
    localparam int COLUMN_W    = 2;
    localparam int MASK_W      = 4;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(2);

    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [MASK_W-1:0]   led_drive;
        logic [MASK_W-1:0]   key_down;
        logic [MASK_W-1:0]   key_up;
    } kmsd_result_t;

endpackage

// ----- rtl/kmsd_column_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmsd_column_update
// Debounce counter and LED toggle update for every row of one column.
// ----------------------------------------------------------------------------
module kmsd_column_update
    import kmsd_pkg::*;
#(
    parameter int ROWS = 4
) (
    input  logic [LEVELS_W-1:0]     row_levels,
    input  logic [COUNT_W-1:0]      limit,
    input  logic [ROWS*COUNT_W-1:0] counts,
    input  logic [ROWS-1:0]         leds,
    output logic [ROWS*COUNT_W-1:0] counts_next,
    output logic [ROWS-1:0]         leds_next,
    output logic [ROWS-1:0]         key_down,
    output logic [ROWS-1:0]         key_up
);

    for (genvar j = 0; j < ROWS; j++) begin : g_row
        logic               pressed;
        logic [COUNT_W-1:0] cnt;
        logic [COUNT_W-1:0] cnt_inc;

        // rows beyond the input pins read as pressed
        if (j < LEVELS_W) begin : g_pin
            assign pressed = ~row_levels[j];
        end else begin : g_nopin
            assign pressed = 1'b1;
        end

        assign cnt     = counts[j*COUNT_W +: COUNT_W];
        assign cnt_inc = cnt + COUNT_W'(1);

        always_comb begin
            counts_next[j*COUNT_W +: COUNT_W] = cnt;
            leds_next[j] = leds[j];
            key_down[j]  = 1'b0;
            key_up[j]    = 1'b0;
            if (pressed) begin
                if (cnt < limit) begin
                    counts_next[j*COUNT_W +: COUNT_W] = cnt_inc;
                    if (cnt_inc == limit) begin
                        key_down[j]  = 1'b1;
                        leds_next[j] = ~leds[j];
                    end
                end
            end else if (cnt != '0) begin
                counts_next[j*COUNT_W +: COUNT_W] = cnt - COUNT_W'(1);
                key_up[j] = (cnt == COUNT_W'(1));
            end
        end
    end

endmodule

// ----- rtl/keypad_matrix_scan_debounce_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_matrix_scan_debounce_top
// Keypad matrix scanner with per-key up/down counter debounce and LED toggle.
//
//   channel | ports                                     | role
//   --------+-------------------------------------------+--------------------
//   s_      | s_valid s_ready s_row_levels[3:0]          | scan step in
//   m_      | m_valid m_ready m_column m_led_drive        | scan result out
//           | m_key_down m_key_up                         |
//   cfg_    | cfg_we cfg_wdata[2:0]                       | debounce limit
//
// One scan step per cycle while the output is not stalled; the result appears in the cycle after acceptance.
// The step is worked out combinationally from the column's stored counts
// and lands in the output register, which also parts the two sides.
// s_ready falls only while a result is held and m_ready is low.
// Synchronous active-low reset clears counts, LEDs, column and m_valid and sets the limit to 2.
// ----------------------------------------------------------------------------
module keypad_matrix_scan_debounce_top
    import kmsd_pkg::*;
#(
    parameter int COLUMNS = 4,
    parameter int ROWS    = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [LEVELS_W-1:0] s_row_levels,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COLUMN_W-1:0] m_column,
    output logic [MASK_W-1:0]   m_led_drive,
    output logic [MASK_W-1:0]   m_key_down,
    output logic [MASK_W-1:0]   m_key_up
);

    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

    logic [COUNT_W-1:0]      limit_reg;
    logic [COL_W-1:0]        col_reg;
    logic [COL_W-1:0]        col_next;
    logic [ROWS*COUNT_W-1:0] count_mem_reg [COLUMNS];
    logic [ROWS-1:0]         led_mem_reg   [COLUMNS];
    logic                    m_valid_reg;
    kmsd_result_t            result_reg;
    kmsd_result_t            result_next;

    logic [ROWS*COUNT_W-1:0] counts_upd;
    logic [ROWS-1:0]         leds_upd;
    logic [ROWS-1:0]         down_vec;
    logic [ROWS-1:0]         up_vec;
    logic                    accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    kmsd_column_update #(
        .ROWS (ROWS)
    ) u_update (
        .row_levels  (s_row_levels),
        .limit       (limit_reg),
        .counts      (count_mem_reg[col_reg]),
        .leds        (led_mem_reg[col_reg]),
        .counts_next (counts_upd),
        .leds_next   (leds_upd),
        .key_down    (down_vec),
        .key_up      (up_vec)
    );

    assign col_next = (col_reg == COL_LAST) ? '0 : col_reg + COL_W'(1);

    always_comb begin
        result_next.column    = COLUMN_W'(col_reg);
        result_next.led_drive = '0;
        result_next.key_down  = '0;
        result_next.key_up    = '0;
        for (int j = 0; j < MASK_W; j++) begin
            if (j < ROWS) begin
                result_next.led_drive[j] = led_mem_reg[col_reg][j % ROWS];
                result_next.key_down[j]  = down_vec[j % ROWS];
                result_next.key_up[j]    = up_vec[j % ROWS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= LIMIT_RESET;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < COLUMNS; c++) begin
                count_mem_reg[c] <= '0;
                led_mem_reg[c]   <= '0;
            end
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (accept) begin
                col_reg                <= col_next;
                count_mem_reg[col_reg] <= counts_upd;
                led_mem_reg[col_reg]   <= leds_upd;
                m_valid_reg            <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_column    = result_reg.column;
    assign m_led_drive = result_reg.led_drive;
    assign m_key_down  = result_reg.key_down;
    assign m_key_up    = result_reg.key_up;

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted scan step produced no result");

    a_column_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> col_reg == $past(col_next))
        else $error("column counter did not advance on a transaction");

    a_events_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (result_reg.key_down & result_reg.key_up) == '0)
        else $error("key down and key up flagged together");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while result stalled");

endmodule
